[sv/sorted_key_table_bisect_insert_assert.svh]
// Assertion macros for the sorted key table checker.
// Included by the checker file; needs no package.
`ifndef SORTED_KEY_TABLE_BISECT_INSERT_ASSERT_SVH
`define SORTED_KEY_TABLE_BISECT_INSERT_ASSERT_SVH

// Clocked assertion, switched off while reset is high.
`define SKTBI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion that also holds through reset.
`define SKTBI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/sktbi_pkg.sv]
// Shared widths, request codes and status codes for the sorted key table.
// No dependencies; used by the interfaces, the top level and the checker.
package sktbi_pkg;

  localparam int KEY_W        = 64;
  localparam int POS_W        = 6;
  localparam int TYPE_W       = 2;
  localparam int STAT_W       = 2;
  localparam int CAPACITY_DEF = 32;

  typedef enum logic [TYPE_W-1:0] {
    REQ_LEFT   = 2'd0,
    REQ_RIGHT  = 2'd1,
    REQ_INSERT = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

endpackage

[sv/sktbi_in_if.sv]
// Request channel: valid/ready handshake carrying one request word.
// Depends on sktbi_pkg.
interface sktbi_in_if;
  import sktbi_pkg::*;

  logic                    valid;
  logic                    ready;
  req_type_t               req_type;
  logic signed [KEY_W-1:0] key;
  logic [POS_W-1:0]        insert_position;

  modport source (output valid, req_type, key, insert_position, input ready);
  modport sink   (input valid, req_type, key, insert_position, output ready);
endinterface

[sv/sktbi_out_if.sv]
// Response channel: valid/ready handshake carrying one result word.
// Depends on sktbi_pkg.
interface sktbi_out_if;
  import sktbi_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  status_t          status;
  logic [POS_W-1:0] entry_count_after;

  modport source (output valid, position, status, entry_count_after, input ready);
  modport sink   (input valid, position, status, entry_count_after, output ready);
endinterface

[sv/sorted_key_table_bisect_insert.sv]
// Sorted key table: left/right bisect and positional insert over a key RAM.
// Depends on sktbi_pkg, sktbi_in_if and sktbi_out_if.
//
//   channel  dir  word fields
//   req      in   req_type, key, insert_position
//   rsp      out  position, status, entry_count_after
//
// Bisect: each halving step is a RAM read, then a compare in the one
// comparator; 6 steps at most for 32 entries.
// Insert: each moved entry is a read, then a write, through the single RAM port pair;
// rejected inserts and unused request types go straight to the result.
// Reset clears the entry count, the state and the output valid; key RAM contents are left as they are.
// req.ready is high whenever no request is in flight, even while a result
// waits in the output register; a stalled rsp holds the finished result.
module sorted_key_table_bisect_insert #(
  parameter int CAPACITY = sktbi_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sktbi_in_if.sink    req,
  sktbi_out_if.source rsp
);
  import sktbi_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_CMP   = 7'b0000100,
    S_SHRD  = 7'b0001000,
    S_SHWR  = 7'b0010000,
    S_INSWR = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t                  state;
  logic [CW-1:0]           count;
  logic [CW-1:0]           lo;
  logic [CW-1:0]           hi;
  logic [CW-1:0]           idx;
  logic signed [KEY_W-1:0] key_q;
  req_type_t               kind;
  logic [POS_W-1:0]        ipos;
  logic [POS_W-1:0]        res_pos;
  status_t                 res_status;

  logic                    out_valid;
  logic [POS_W-1:0]        out_pos;
  status_t                 out_status;
  logic [POS_W-1:0]        out_count;

  logic signed [KEY_W-1:0] mem [CAPACITY];
  logic signed [KEY_W-1:0] rd_data;

  logic [CW:0]             mid_sum;
  logic [CW-1:0]           mid;
  logic [CW-1:0]           idx_m1;
  logic                    go_right;
  logic [CW-1:0]           lo_next;
  logic [CW-1:0]           hi_next;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [KEY_W-1:0] wr_data;
  logic                    in_acc;
  logic                    out_load;

  assign in_acc   = req.valid && req.ready;
  assign out_load = (state == S_FIN) && (!out_valid || rsp.ready);

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CW:1];
  assign idx_m1  = idx - CW'(1);

  // left bisect moves right on mem < key, right bisect also on equality
  assign go_right = (rd_data < key_q) || ((kind == REQ_RIGHT) && (rd_data == key_q));
  assign lo_next  = go_right ? (mid + CW'(1)) : lo;
  assign hi_next  = go_right ? hi : mid;

  assign rd_en   = (state == S_READ) || (state == S_SHRD);
  assign rd_addr = (state == S_READ) ? mid[AW-1:0] : idx_m1[AW-1:0];
  assign wr_en   = (state == S_SHWR) || (state == S_INSWR);
  assign wr_addr = (state == S_SHWR) ? idx[AW-1:0] : AW'(ipos);
  assign wr_data = (state == S_SHWR) ? rd_data : key_q;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid  <= 1'b1;
        out_pos    <= res_pos;
        out_status <= res_status;
        out_count  <= POS_W'(count);
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            key_q      <= req.key;
            kind       <= req.req_type;
            ipos       <= req.insert_position;
            lo         <= '0;
            hi         <= count;
            idx        <= count;
            res_status <= ST_OK;
            case (req.req_type)
              REQ_LEFT, REQ_RIGHT: begin
                res_pos <= '0;
                state   <= (count == '0) ? S_FIN : S_READ;
              end
              REQ_INSERT: begin
                res_pos <= req.insert_position;
                if (count >= CAP_C) begin
                  res_status <= ST_FULL;
                  state      <= S_FIN;
                end else if (XW'(req.insert_position) > XW'(count)) begin
                  res_status <= ST_RANGE;
                  state      <= S_FIN;
                end else if (XW'(req.insert_position) == XW'(count)) begin
                  state <= S_INSWR;
                end else begin
                  state <= S_SHRD;
                end
              end
              default: begin
                res_pos <= '0;
                state   <= S_FIN;
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          lo <= lo_next;
          hi <= hi_next;
          if (lo_next >= hi_next) begin
            res_pos <= POS_W'(lo_next);
            state   <= S_FIN;
          end else begin
            state <= S_READ;
          end
        end
        S_SHRD: begin
          state <= S_SHWR;
        end
        S_SHWR: begin
          idx <= idx_m1;
          // last move done once the hole reaches the insert position
          state <= (XW'(idx_m1) == XW'(ipos)) ? S_INSWR : S_SHRD;
        end
        S_INSWR: begin
          count <= count + CW'(1);
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready             = (state == S_IDLE);
  assign rsp.valid             = out_valid;
  assign rsp.position          = out_pos;
  assign rsp.status            = out_status;
  assign rsp.entry_count_after = out_count;

endmodule

[sv/sktbi_checker.sv]
// Port-level checker for the sorted key table, bound to the top level.
// Depends on sktbi_pkg and sorted_key_table_bisect_insert_assert.svh.
`include "sorted_key_table_bisect_insert_assert.svh"

module sktbi_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [sktbi_pkg::POS_W-1:0]  position,
  input logic [sktbi_pkg::STAT_W-1:0] status,
  input logic [sktbi_pkg::POS_W-1:0]  count_after
);
  import sktbi_pkg::*;

  // a stalled result word holds
  `SKTBI_ASSERT(a_rsp_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(position) && $stable(status) && $stable(count_after), "rsp word changed while stalled")

  // one request at a time: busy right after an accept
  `SKTBI_ASSERT(a_busy_after_accept, clk, rst, in_valid && in_ready |=> !in_ready, "req accepted while a request was in flight")

  // a position-range reject always names a position past the count
  `SKTBI_ASSERT(a_range_reject, clk, rst, out_valid && (status == ST_RANGE) |-> position > count_after, "range reject with position within count")

  `SKTBI_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !out_valid, "rsp valid after reset")

endmodule

bind sorted_key_table_bisect_insert sktbi_checker u_sktbi_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .position    (rsp.position),
  .status      (rsp.status),
  .count_after (rsp.entry_count_after)
);

[dv/tb_top.sv]
// Self-checking bench for sorted_key_table_bisect_insert: bisect and insert
// requests are checked against a key-table predictor that lives in this bench.
// Depends on sktbi_pkg, sktbi_in_if, sktbi_out_if and the block itself.
module tb_top;
  import sktbi_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LO    = 200;
  localparam int QUIET_HI    = 300;
  localparam int N_RANDOM    = 430;
  localparam int DISORDER_AT = 340;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  // How insert_position and key are settled when the word goes out
  typedef enum {POS_GIVEN, POS_SORTED, POS_BEYOND} pos_pick_t;
  typedef enum {KEY_GIVEN, KEY_NEAR_STORED} key_pick_t;

  typedef struct {
    req_type_t               kind;
    logic signed [KEY_W-1:0] key;
    logic [POS_W-1:0]        ipos;
    pos_pick_t               pos_pick;
    key_pick_t               key_pick;
    bit                      drain;
  } key_req_t;

  typedef struct {
    logic [POS_W-1:0] position;
    status_t          status;
    logic [POS_W-1:0] count_after;
  } key_rsp_t;

  logic clk = 1'b0;
  logic rst;

  sktbi_in_if  req ();
  sktbi_out_if rsp ();

  sorted_key_table_bisect_insert #(.CAPACITY(CAP)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #2 clk = ~clk;

  // Predicted key table
  logic signed [KEY_W-1:0] key_row [CAP];
  int unsigned             row_count = 0;

  key_req_t req_backlog [$];
  key_rsp_t rsp_due_q [$];
  key_req_t word_on_bus;

  int n_sent = 0;
  int n_got = 0;
  int n_errors = 0;
  int plan_count = 0;
  int stall_cycles = 0;

  function automatic int unsigned bisect(logic signed [KEY_W-1:0] q, bit upper);
    int unsigned lo, hi, mid;
    bit          go_up;
    lo = 0;
    hi = row_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      go_up = upper ? !(q < key_row[mid]) : (key_row[mid] < q);
      if (go_up) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Applies one request to the predicted table and returns its result word
  function automatic key_rsp_t table_step(key_req_t r);
    key_rsp_t res;
    res.position = '0;
    res.status   = ST_OK;
    case (r.kind)
      REQ_LEFT:  res.position = POS_W'(bisect(r.key, 1'b0));
      REQ_RIGHT: res.position = POS_W'(bisect(r.key, 1'b1));
      REQ_INSERT: begin
        res.position = r.ipos;
        if (row_count >= CAP) res.status = ST_FULL;
        else if (r.ipos > row_count) res.status = ST_RANGE;
        else begin
          for (int i = row_count; i > r.ipos; i--) key_row[i] = key_row[i-1];
          key_row[r.ipos] = r.key;
          row_count++;
        end
      end
      default: ;
    endcase
    res.count_after = POS_W'(row_count);
    return res;
  endfunction

  // Settles key and position against the table as it stands when the word goes out
  function automatic key_req_t settle_request(key_req_t r);
    int unsigned idx;
    if (r.key_pick == KEY_NEAR_STORED && row_count > 0) begin
      idx = $urandom_range(row_count - 1);
      case ($urandom_range(2))
        0:       r.key = key_row[idx] - 1;
        1:       r.key = key_row[idx];
        default: r.key = key_row[idx] + 1;
      endcase
    end
    if (r.pos_pick == POS_SORTED)
      r.ipos = POS_W'(bisect(r.key, 1'($urandom_range(1))));
    else if (r.pos_pick == POS_BEYOND)
      r.ipos = POS_W'($urandom_range(2**POS_W - 1, row_count + 1));
    return r;
  endfunction

  function automatic logic signed [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_req(req_type_t kind, logic signed [KEY_W-1:0] key,
                           int ipos, pos_pick_t pp, key_pick_t kp, bit drain);
    key_req_t r;
    r.kind     = kind;
    r.key      = key;
    r.ipos     = POS_W'(ipos);
    r.pos_pick = pp;
    r.key_pick = kp;
    r.drain    = drain;
    req_backlog.push_back(r);
    // Track how many inserts will land so the table fills late in the run
    if (kind == REQ_INSERT && plan_count < CAP &&
        (pp == POS_SORTED || (pp == POS_GIVEN && ipos <= plan_count)))
      plan_count++;
  endtask

  // Random key for a request: near a stored key, fully random, or one of KEY_MIN, KEY_MAX, 0, -1 and 1
  task automatic pick_key(output logic signed [KEY_W-1:0] k, output key_pick_t kp);
    int roll;
    roll = $urandom_range(99);
    kp = KEY_GIVEN;
    if (roll < 40) begin
      kp = KEY_NEAR_STORED;
      k = rand_key();
    end else if (roll < 80) k = rand_key();
    else begin
      case ($urandom_range(4))
        0:       k = KEY_MIN;
        1:       k = KEY_MAX;
        2:       k = 0;
        3:       k = -1;
        default: k = 1;
      endcase
    end
  endtask

  task automatic report_mismatch(string what);
    $display("%0d: result %0d: %s", $time, n_got, what);
    n_errors++;
  endtask

  // Driver: holds a word until accepted; predicts on every accepted request
  always @(posedge clk) begin : driver
    bit fire, quiet, nv;
    key_rsp_t res;
    fire = req.valid && req.ready;
    if (!rst) begin
      if (fire) begin
        res = table_step(word_on_bus);
        rsp_due_q.push_back(res);
        n_sent++;
      end
      if (!req.valid || fire) begin
        nv = 1'b0;
        quiet = n_sent >= QUIET_LO && n_sent < QUIET_HI;
        if (req_backlog.size() > 0 &&
            !(req_backlog[0].drain && rsp_due_q.size() > 0) &&
            (quiet || $urandom_range(99) >= 12)) begin
          word_on_bus = settle_request(req_backlog.pop_front());
          req.req_type        <= word_on_bus.kind;
          req.key             <= word_on_bus.key;
          req.insert_position <= word_on_bus.ipos;
          nv = 1'b1;
        end
        req.valid <= nv;
      end
    end
  end

  // Monitor: random and one long back-pressure stretch, field-by-field check
  always @(posedge clk) begin : monitor
    key_rsp_t want;
    bit       rdy;
    int       hold_left;
    bit       held;
    if (rst) begin
      hold_left = 0;
      held = 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (rsp_due_q.size() == 0) report_mismatch("result with no request pending");
        else begin
          want = rsp_due_q.pop_front();
          if (rsp.position !== want.position)
            report_mismatch($sformatf("position %0d, want %0d",
                                      rsp.position, want.position));
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
          if (rsp.entry_count_after !== want.count_after)
            report_mismatch($sformatf("entry_count_after %0d, want %0d",
                                      rsp.entry_count_after, want.count_after));
        end
        n_got++;
      end
      if (n_got == HOLD_AT && !held) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (n_got >= QUIET_LO && n_got < QUIET_HI) rdy = 1'b1;
      else rdy = $urandom_range(99) >= 12;
      rsp.ready <= rdy;
    end
  end

  always @(posedge clk) begin : watchdog
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_cycles <= 0;
    else if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else stall_cycles <= stall_cycles + 1;
  end

  initial begin : stimulus
    int roll;
    logic signed [KEY_W-1:0] k;
    key_pick_t kp;
    req.valid = 1'b0;
    req.req_type = REQ_LEFT;
    req.key = '0;
    req.insert_position = '0;
    rsp.ready = 1'b0;
    rst = 1'b1;

    // Directed: empty table, range errors, extremes, duplicates, unused type
    queue_req(REQ_LEFT,   0,       0,  POS_GIVEN,  KEY_GIVEN, 0);
    queue_req(REQ_RIGHT,  KEY_MIN, 0,  POS_GIVEN,  KEY_GIVEN, 0);
    queue_req(REQ_INSERT, 5,       1,  POS_GIVEN,  KEY_GIVEN, 0);
    queue_req(REQ_INSERT, 5,       63, POS_GIVEN,  KEY_GIVEN, 0);
    queue_req(REQ_INSERT, 0,       0,  POS_GIVEN,  KEY_GIVEN, 0);
    queue_req(REQ_INSERT, KEY_MIN, 0,  POS_GIVEN,  KEY_GIVEN, 0);
    queue_req(REQ_INSERT, KEY_MAX, 2,  POS_GIVEN,  KEY_GIVEN, 0);
    queue_req(REQ_INSERT, 0,       2,  POS_GIVEN,  KEY_GIVEN, 0);
    queue_req(REQ_INSERT, -1,      1,  POS_GIVEN,  KEY_GIVEN, 0);
    queue_req(REQ_LEFT,   0,       0,  POS_GIVEN,  KEY_GIVEN, 0);
    queue_req(REQ_RIGHT,  0,       0,  POS_GIVEN,  KEY_GIVEN, 0);
    queue_req(REQ_LEFT,   KEY_MIN, 0,  POS_GIVEN,  KEY_GIVEN, 0);
    queue_req(REQ_RIGHT,  KEY_MIN, 0,  POS_GIVEN,  KEY_GIVEN, 0);
    queue_req(REQ_LEFT,   KEY_MAX, 0,  POS_GIVEN,  KEY_GIVEN, 0);
    queue_req(REQ_RIGHT,  KEY_MAX, 0,  POS_GIVEN,  KEY_GIVEN, 0);
    queue_req(REQ_LEFT,   -1,      0,  POS_GIVEN,  KEY_GIVEN, 0);
    queue_req(REQ_RIGHT,  1,       0,  POS_GIVEN,  KEY_GIVEN, 0);
    queue_req(REQ_NONE,   -1,      63, POS_GIVEN,  KEY_GIVEN, 0);
    queue_req(REQ_INSERT, 64'sh5555_5555_5555_5555, 0, POS_SORTED, KEY_GIVEN, 0);
    queue_req(REQ_INSERT, 64'shAAAA_AAAA_AAAA_AAAA, 0, POS_SORTED, KEY_GIVEN, 0);
    queue_req(REQ_INSERT, KEY_MAX, 0,  POS_SORTED, KEY_GIVEN, 0);
    queue_req(REQ_INSERT, 7,       0,  POS_BEYOND, KEY_GIVEN, 0);

    // Random: sorted inserts spread out so bisects see every table size
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == DISORDER_AT) begin
        while (plan_count < CAP - 1) begin
          pick_key(k, kp);
          queue_req(REQ_INSERT, k, 0, POS_SORTED, kp, 0);
        end
        // Last free slot: an out-of-order key, later bisects search an unsorted table
        queue_req(REQ_INSERT, KEY_MAX, 0, POS_GIVEN, KEY_GIVEN, 0);
      end
      roll = $urandom_range(99);
      pick_key(k, kp);
      if (roll < 9 && (plan_count < CAP - 1 || i > DISORDER_AT))
        queue_req(REQ_INSERT, k, 0, POS_SORTED, kp, i == 40 || i == 360);
      else if (roll < 14)
        queue_req(REQ_INSERT, k, 0, POS_BEYOND, kp, i == 40 || i == 360);
      else if (roll < 17)
        queue_req(REQ_NONE, rand_key(), $urandom_range(63), POS_GIVEN, KEY_GIVEN,
                  i == 40 || i == 360);
      else
        queue_req(roll < 58 ? REQ_LEFT : REQ_RIGHT, k, $urandom_range(63), POS_GIVEN, kp,
                  i == 40 || i == 360);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (req_backlog.size() != 0 || req.valid || rsp_due_q.size() != 0)
      @(negedge clk);
    repeat (100) @(negedge clk);
    if (n_errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
